[hdl/sgcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcp_pkg: shared types for the scatter-gather copy planner
// Transaction types, status codes and the depth default used by the design modules.
// ----------------------------------------------------------------------------
package sgcp_pkg;

	localparam int DEST_DEPTH_DEF = 32;

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_SEG  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_BUSY      = 2'd0,
		STAT_DONE      = 2'd1,
		STAT_EXHAUSTED = 2'd2,
		STAT_EMPTY     = 2'd3
	} stat_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] addr;
		logic [31:0] len;
		logic        fin;
	} cmd_t;

	typedef struct packed {
		logic [63:0] src_addr;
		logic [63:0] dst_addr;
		logic [31:0] copy_len;
		logic [4:0]  dest_index;
		logic        dest_closed;
		logic [31:0] dest_new_len;
		stat_t       status;
		logic [5:0]  entries_used;
		logic        run_end;
	} result_t;

endpackage

[hdl/sgcp_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcp_in_if: input channel of the copy planner
// Valid/ready channel carrying destination loads and source segments.
// ----------------------------------------------------------------------------
interface sgcp_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [63:0] seg_addr;
	logic [31:0] seg_len;
	logic        is_final;

	modport source (output valid, action, seg_addr, seg_len, is_final, input ready);
	modport sink (input valid, action, seg_addr, seg_len, is_final, output ready);
endinterface

[hdl/sgcp_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcp_out_if: command channel of the copy planner
// Valid/ready channel carrying copy commands and run status.
// ----------------------------------------------------------------------------
interface sgcp_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] src_addr;
	logic [63:0] dst_addr;
	logic [31:0] copy_len;
	logic [4:0]  dest_index;
	logic        dest_closed;
	logic [31:0] dest_new_len;
	logic [1:0]  status;
	logic [5:0]  entries_used;
	logic        run_end;

	modport source (output valid, src_addr, dst_addr, copy_len, dest_index, dest_closed,
		dest_new_len, status, entries_used, run_end, input ready);
	modport sink (input valid, src_addr, dst_addr, copy_len, dest_index, dest_closed,
		dest_new_len, status, entries_used, run_end, output ready);
endinterface

[hdl/sgcp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcp_front: intake stage
// Registers each input transaction and classifies it as load or segment.
// ----------------------------------------------------------------------------
module sgcp_front (
	input  logic             clk,
	input  logic             arst_n,
	sgcp_in_if.sink          items,
	output sgcp_pkg::cmd_t   cmd,
	output logic             cmd_valid,
	input  logic             cmd_ready
);

	logic           vld_q;
	sgcp_pkg::cmd_t cmd_q;

	assign items.ready = !vld_q || cmd_ready;
	assign cmd_valid   = vld_q;
	assign cmd         = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (items.ready) begin
			vld_q <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_q.op   <= items.action ? sgcp_pkg::OP_SEG : sgcp_pkg::OP_LOAD;
			cmd_q.addr <= items.seg_addr;
			cmd_q.len  <= items.seg_len;
			cmd_q.fin  <= items.is_final;
		end
	end

endmodule

[hdl/sgcp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcp_queue: two-entry command queue
// Decouples the intake stage from the execution engine.
// ----------------------------------------------------------------------------
module sgcp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  sgcp_pkg::cmd_t   in_cmd,
	input  logic             in_valid,
	output logic             in_ready,
	output sgcp_pkg::cmd_t   out_cmd,
	output logic             out_valid,
	input  logic             out_ready
);

	sgcp_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     fill_q;
	logic           push;
	logic           pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

[hdl/sgcp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgcp_back: execution engine
// Holds the destination table, splits segments into copy pieces and
// drives the registered command output.
// ----------------------------------------------------------------------------
module sgcp_back #(
	parameter int DEST_DEPTH = sgcp_pkg::DEST_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sgcp_pkg::cmd_t   q_cmd,
	input  logic             q_valid,
	output logic             q_ready,
	sgcp_out_if.source       cmds
);

	localparam int         IW      = (DEST_DEPTH > 1) ? $clog2(DEST_DEPTH) : 1;
	localparam logic [5:0] DEPTH_W = 6'(DEST_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EXEC = 3'b100
	} state_t;

	logic [63:0] addr_mem [DEST_DEPTH];
	logic [31:0] len_mem [DEST_DEPTH];

	state_t      state_q, state_d;
	logic [63:0] rd_addr_q;
	logic [31:0] rd_len_q;
	logic [5:0]  count_q, count_d;
	logic [5:0]  cur_q, cur_d;
	logic [31:0] rem_q, rem_d;
	logic [31:0] filled_q, filled_d;
	logic        loaded_q, loaded_d;
	logic        failed_q, failed_d;
	logic        open_q, open_d;
	logic [63:0] sa_q, sa_d;
	logic [31:0] sl_q, sl_d;
	logic        fin_q, fin_d;

	sgcp_pkg::result_t res_q, res_d;
	logic              res_vld_q;
	logic              out_free;
	logic              emit;

	logic [31:0] dl;
	logic [31:0] filled;
	logic [63:0] da;
	logic [5:0]  next;
	logic [5:0]  cnt_eff;
	logic [31:0] nl_short;
	logic [31:0] nl_full;
	logic        addr_we;
	logic [IW-1:0] addr_widx;
	logic        len_we;
	logic [IW-1:0] len_widx;
	logic [31:0] len_wdata;

	assign out_free = !res_vld_q || cmds.ready;
	assign dl       = open_q ? rd_len_q : rem_q;
	assign filled   = open_q ? 32'd0 : filled_q;
	assign da       = rd_addr_q + {32'd0, filled};
	assign next     = cur_q + 6'd1;
	assign nl_short = filled + sl_q;
	assign nl_full  = filled + dl;
	assign cnt_eff  = loaded_q ? 6'd0 : count_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		cur_d     = cur_q;
		rem_d     = rem_q;
		filled_d  = filled_q;
		loaded_d  = loaded_q;
		failed_d  = failed_q;
		open_d    = open_q;
		sa_d      = sa_q;
		sl_d      = sl_q;
		fin_d     = fin_q;
		q_ready   = 1'b0;
		emit      = 1'b0;
		res_d     = '0;
		addr_we   = 1'b0;
		addr_widx = cnt_eff[IW-1:0];
		len_we    = 1'b0;
		len_widx  = cur_q[IW-1:0];
		len_wdata = q_cmd.len;

		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_cmd.op == sgcp_pkg::OP_LOAD) begin
						q_ready = 1'b1;
						if (loaded_q) begin
							cur_d    = 6'd0;
							rem_d    = 32'd0;
							filled_d = 32'd0;
							loaded_d = 1'b0;
							failed_d = 1'b0;
							open_d   = 1'b0;
						end
						count_d = cnt_eff;
						if (cnt_eff < DEPTH_W) begin
							addr_we  = 1'b1;
							len_we   = 1'b1;
							len_widx = cnt_eff[IW-1:0];
							count_d  = cnt_eff + 6'd1;
						end
						if (q_cmd.fin) begin
							loaded_d = 1'b1;
							cur_d    = 6'd0;
							open_d   = 1'b1;
						end
					end else if (out_free) begin
						q_ready = 1'b1;
						if (count_q == 6'd0) begin
							emit          = 1'b1;
							res_d.status  = sgcp_pkg::STAT_EMPTY;
							res_d.run_end = 1'b1;
						end else if (loaded_q && (failed_q || cur_q >= count_q)) begin
							emit          = 1'b1;
							res_d.status  = sgcp_pkg::STAT_EXHAUSTED;
							res_d.run_end = 1'b1;
						end else begin
							loaded_d = 1'b1;
							if (!loaded_q) begin
								cur_d  = 6'd0;
								open_d = 1'b1;
							end
							sa_d    = q_cmd.addr;
							sl_d    = q_cmd.len;
							fin_d   = q_cmd.fin;
							state_d = ST_READ;
						end
					end
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					emit             = 1'b1;
					res_d.src_addr   = sa_q;
					res_d.dst_addr   = da;
					res_d.dest_index = cur_q[4:0];
					state_d          = ST_IDLE;
					if (sl_q < dl) begin
						res_d.copy_len = sl_q;
						res_d.run_end  = 1'b1;
						if (fin_q) begin
							res_d.dest_closed  = 1'b1;
							res_d.dest_new_len = nl_short;
							res_d.status       = sgcp_pkg::STAT_DONE;
							res_d.entries_used = next;
							len_we             = 1'b1;
							len_wdata          = nl_short;
							count_d            = next;
							cur_d              = 6'd0;
							open_d             = 1'b1;
						end else begin
							rem_d    = dl - sl_q;
							filled_d = nl_short;
							open_d   = 1'b0;
						end
					end else begin
						res_d.copy_len     = dl;
						res_d.dest_closed  = 1'b1;
						res_d.dest_new_len = nl_full;
						len_we             = 1'b1;
						len_wdata          = nl_full;
						if (sl_q == dl && fin_q) begin
							res_d.status       = sgcp_pkg::STAT_DONE;
							res_d.entries_used = next;
							res_d.run_end      = 1'b1;
							count_d            = next;
							cur_d              = 6'd0;
							open_d             = 1'b1;
						end else if (next >= count_q) begin
							res_d.status  = sgcp_pkg::STAT_EXHAUSTED;
							res_d.run_end = 1'b1;
							failed_d      = 1'b1;
							cur_d         = next;
							rem_d         = 32'd0;
							filled_d      = 32'd0;
							open_d        = 1'b0;
						end else begin
							cur_d  = next;
							open_d = 1'b1;
							if (sl_q == dl) begin
								res_d.run_end = 1'b1;
							end else begin
								sa_d    = sa_q + {32'd0, dl};
								sl_d    = sl_q - dl;
								state_d = ST_READ;
							end
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= 6'd0;
			cur_q     <= 6'd0;
			rem_q     <= 32'd0;
			filled_q  <= 32'd0;
			loaded_q  <= 1'b0;
			failed_q  <= 1'b0;
			open_q    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cur_q    <= cur_d;
			rem_q    <= rem_d;
			filled_q <= filled_d;
			loaded_q <= loaded_d;
			failed_q <= failed_d;
			open_q   <= open_d;
			if (emit) begin
				res_vld_q <= 1'b1;
			end else if (cmds.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sa_q  <= sa_d;
		sl_q  <= sl_d;
		fin_q <= fin_d;
		if (emit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (addr_we) begin
			addr_mem[addr_widx] <= q_cmd.addr;
		end
		if (len_we) begin
			len_mem[len_widx] <= len_wdata;
		end
		if (state_q == ST_READ) begin
			rd_addr_q <= addr_mem[cur_q[IW-1:0]];
			rd_len_q  <= len_mem[cur_q[IW-1:0]];
		end
	end

	assign cmds.valid        = res_vld_q;
	assign cmds.src_addr     = res_q.src_addr;
	assign cmds.dst_addr     = res_q.dst_addr;
	assign cmds.copy_len     = res_q.copy_len;
	assign cmds.dest_index   = res_q.dest_index;
	assign cmds.dest_closed  = res_q.dest_closed;
	assign cmds.dest_new_len = res_q.dest_new_len;
	assign cmds.status       = res_q.status;
	assign cmds.entries_used = res_q.entries_used;
	assign cmds.run_end      = res_q.run_end;

endmodule

[hdl/scatter_gather_copy_planner.sv]
`timescale 1ns / 1ps
// Path: a source segment passes the intake register, the command queue, the table read
//   and execute states and the output register. Loads and refused segments finish in idle;
//   a segment splits into pieces, a table read then execute each, holding off the queue.
// Reset: arst_n clears all control state; the destination table contents are undefined
//   until loaded, and no clearing pass runs.
// ----------------------------------------------------------------------------
// scatter_gather_copy_planner: top level
// Intake stage, command queue and execution engine for scatter-gather copy
// planning against a loaded destination table.
// ----------------------------------------------------------------------------
module scatter_gather_copy_planner #(
	parameter int DEST_DEPTH = sgcp_pkg::DEST_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sgcp_in_if.sink    items,
	sgcp_out_if.source cmds
);

	sgcp_pkg::cmd_t f_cmd;
	logic           f_valid;
	logic           f_ready;
	sgcp_pkg::cmd_t q_cmd;
	logic           q_valid;
	logic           q_ready;

	sgcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready)
	);

	sgcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (f_cmd),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.out_cmd   (q_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready)
	);

	sgcp_back #(
		.DEST_DEPTH (DEST_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (q_cmd),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.cmds    (cmds)
	);

endmodule
